### hw/rtl/bts_pkg.sv
// Package for the backtrack trail store: sizes, operation codes and FSM state type.
// No dependencies.
`default_nettype none
package bts_pkg;
  localparam int unsigned CELLS       = 256;
  localparam int unsigned TRAIL_DEPTH = 1024;
  localparam int unsigned LEVEL_DEPTH = 64;
  localparam int unsigned CELL_W  = $clog2(CELLS);
  localparam int unsigned TRAIL_W = $clog2(TRAIL_DEPTH);
  localparam int unsigned LEVEL_W = $clog2(LEVEL_DEPTH);
  localparam int unsigned TCNT_W  = $clog2(TRAIL_DEPTH + 1);
  localparam int unsigned LCNT_W  = $clog2(LEVEL_DEPTH + 1);

  typedef enum logic [3:0] {
    OP_INIT   = 4'd0,
    OP_SET    = 4'd1,
    OP_GET    = 4'd2,
    OP_MARK   = 4'd3,
    OP_UNDO   = 4'd4,
    OP_COMMIT = 4'd5,
    OP_PAUSE  = 4'd6,
    OP_RESUME = 4'd7,
    OP_RESET  = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_UNWIND_RD,
    ST_UNWIND_WR,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

### hw/rtl/backtrack_trail_store.sv
// Backtrack trail store top level: cell memory, undo trail, level stack and sequencer.
// Depends on bts_pkg.
//
// Channel  Direction  Handshake                 Beat contents
// in       input      in_valid_i/in_stall_o     kind, cell_index, value, write-once, mark
// out      output     out_valid_o/out_stall_i   ok, read data, new mark, level/trail counts
//
// Every kind walks idle, read, execute and done: the result beat is offered in done,
// and the next input beat is taken in idle once out_stall_i has let the result go.
// Undo adds a read-trail and a write-cell step per trail entry popped and commit a
// read-trail step per entry, and both end with a step that closes the levels. Each
// store is used through a single memory port. Reset clears the state and counters and
// sets the generation to one; memories hold garbage until written. The input
// is stalled from accepting a beat until its result beat has been taken.
`default_nettype none
module backtrack_trail_store
  import bts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic [7:0]  cell_index_i,
  input  wire logic signed [63:0] write_value_i,
  input  wire logic        write_once_flag_i,
  input  wire logic [6:0]  mark_level_i,
  input  wire logic [31:0] mark_generation_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             ok_o,
  output logic signed [63:0] read_value_o,
  output logic             read_bound_o,
  output logic [6:0]       new_mark_level_o,
  output logic [31:0]      new_mark_generation_o,
  output logic [6:0]       level_now_o,
  output logic [10:0]      trail_now_o,
  output logic             trailing_paused_o
);
  // memories
  logic [63:0]      cval_mem [CELLS];
  logic [6:0]       cstp_mem [CELLS];
  logic             cbnd_mem [CELLS];
  logic             conce_mem[CELLS];
  logic [CELL_W-1:0] tcell_mem[TRAIL_DEPTH];
  logic [63:0]      tval_mem [TRAIL_DEPTH];
  logic [6:0]       tstp_mem [TRAIL_DEPTH];
  logic             tbnd_mem [TRAIL_DEPTH];
  logic [TCNT_W-1:0] lbase_mem[LEVEL_DEPTH];
  logic [31:0]      lgen_mem [LEVEL_DEPTH];

  state_e state_q, state_d;

  // captured input beat
  logic [3:0]  kind_q;
  logic [7:0]  idx_q;
  logic [63:0] wval_q;
  logic        once_q;
  logic [6:0]  mlvl_q;
  logic [31:0] mgen_q;

  // counters
  logic [TCNT_W-1:0] tcnt_q, tcnt_d;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [7:0]        pcnt_q, pcnt_d;
  logic [31:0]       gen_q, gen_d;

  // registered read data
  logic [63:0] rd_val_q;
  logic [6:0]  rd_stp_q;
  logic        rd_bnd_q, rd_once_q;
  logic [TCNT_W-1:0] rd_base_q;
  logic [31:0]       rd_gen_q;
  logic [CELL_W-1:0] tr_cell_q;
  logic [63:0] tr_val_q;
  logic [6:0]  tr_stp_q;
  logic        tr_bnd_q;

  // result registers
  logic        ok_q, ok_d;
  logic [63:0] rval_q, rval_d;
  logic        rbnd_q, rbnd_d;
  logic [6:0]  nlvl_q, nlvl_d;
  logic [31:0] ngen_q, ngen_d;

  logic cell_ok, live, is_restore, accept, need_trail;
  logic [LEVEL_W-1:0] mslot;
  logic [CELL_W-1:0] cidx;
  logic [TRAIL_W-1:0] tpop;

  assign cell_ok = ({24'd0, idx_q} < 32'(CELLS));
  assign cidx    = idx_q[CELL_W-1:0];
  assign mslot   = LEVEL_W'(mlvl_q - 7'd1);
  assign live    = (mlvl_q != 7'd0) && (LCNT_W'(mlvl_q) <= lcnt_q) && (rd_gen_q == mgen_q);
  assign is_restore = (kind_q == OP_UNDO);
  assign tpop    = TRAIL_W'(tcnt_q - TCNT_W'(1));
  assign accept  = in_valid_i && !in_stall_o;
  assign need_trail = (lcnt_q != '0) && (pcnt_q == 8'd0) && (LCNT_W'(rd_stp_q) < lcnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if ((kind_q == OP_UNDO || kind_q == OP_COMMIT) && live) state_d = ST_UNWIND_RD;
        else state_d = ST_DONE;
      end
      ST_UNWIND_RD: begin
        if (tcnt_q <= rd_base_q) state_d = ST_DONE;
        else if (is_restore) state_d = ST_UNWIND_WR;
      end
      ST_UNWIND_WR: state_d = ST_UNWIND_RD;
      ST_DONE: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_DONE);
  end

  // counter and result updates
  always_comb begin
    tcnt_d = tcnt_q; lcnt_d = lcnt_q; pcnt_d = pcnt_q; gen_d = gen_q;
    ok_d = ok_q; rval_d = rval_q; rbnd_d = rbnd_q; nlvl_d = nlvl_q; ngen_d = ngen_q;
    if (state_q == ST_EXEC) begin
      ok_d = 1'b0; rval_d = '0; rbnd_d = 1'b0; nlvl_d = '0; ngen_d = '0;
      unique case (kind_q)
        OP_INIT: ok_d = cell_ok;
        OP_SET: begin
          if (cell_ok && !(rd_once_q && rd_bnd_q)) begin
            if (need_trail) begin
              if (tcnt_q < TCNT_W'(TRAIL_DEPTH)) begin
                ok_d = 1'b1; tcnt_d = tcnt_q + TCNT_W'(1);
              end
            end else ok_d = 1'b1;
          end
        end
        OP_GET: if (cell_ok) begin
          ok_d = 1'b1; rval_d = rd_val_q; rbnd_d = rd_bnd_q;
        end
        OP_MARK: if (lcnt_q < LCNT_W'(LEVEL_DEPTH)) begin
          gen_d = gen_q + 32'd1;
          lcnt_d = lcnt_q + LCNT_W'(1);
          nlvl_d = 7'(lcnt_q + LCNT_W'(1));
          ngen_d = gen_q + 32'd1;
          ok_d = 1'b1;
        end
        OP_UNDO, OP_COMMIT: ok_d = live;
        OP_PAUSE: begin
          ok_d = 1'b1; if (pcnt_q != 8'hFF) pcnt_d = pcnt_q + 8'd1;
        end
        OP_RESUME: begin
          ok_d = 1'b1; if (pcnt_q != 8'd0) pcnt_d = pcnt_q - 8'd1;
        end
        OP_RESET: begin
          ok_d = 1'b1; tcnt_d = '0; lcnt_d = '0; pcnt_d = '0;
        end
        default: ok_d = 1'b0;
      endcase
    end else if (state_q == ST_UNWIND_RD) begin
      // pop one entry; once the trail is down to the level's base, close the levels
      if (tcnt_q > rd_base_q) tcnt_d = tcnt_q - TCNT_W'(1);
      else lcnt_d = LCNT_W'(mlvl_q - 7'd1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tcnt_q  <= '0;
      lcnt_q  <= '0;
      pcnt_q  <= '0;
      gen_q   <= 32'd1;
    end else begin
      state_q <= state_d;
      tcnt_q  <= tcnt_d;
      lcnt_q  <= lcnt_d;
      pcnt_q  <= pcnt_d;
      gen_q   <= gen_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i; idx_q <= cell_index_i; wval_q <= write_value_i;
      once_q <= write_once_flag_i; mlvl_q <= mark_level_i; mgen_q <= mark_generation_i;
    end
    ok_q <= ok_d; rval_q <= rval_d; rbnd_q <= rbnd_d; nlvl_q <= nlvl_d; ngen_q <= ngen_d;
  end

  // cell memory: read in ST_READ, write in ST_EXEC or ST_UNWIND_WR
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_val_q  <= cval_mem[cidx];
      rd_stp_q  <= cstp_mem[cidx];
      rd_bnd_q  <= cbnd_mem[cidx];
      rd_once_q <= conce_mem[cidx];
    end
    if (state_q == ST_EXEC && cell_ok) begin
      if (kind_q == OP_INIT) begin
        cval_mem[cidx]  <= wval_q;
        cstp_mem[cidx]  <= 7'(lcnt_q);
        cbnd_mem[cidx]  <= !once_q;
        conce_mem[cidx] <= once_q;
      end else if (kind_q == OP_SET && !(rd_once_q && rd_bnd_q) &&
                   !(need_trail && tcnt_q >= TCNT_W'(TRAIL_DEPTH))) begin
        cval_mem[cidx] <= wval_q;
        cbnd_mem[cidx] <= 1'b1;
        if (need_trail) cstp_mem[cidx] <= 7'(lcnt_q);
      end
    end else if (state_q == ST_UNWIND_WR) begin
      cval_mem[tr_cell_q] <= tr_val_q;
      cstp_mem[tr_cell_q] <= tr_stp_q;
      cbnd_mem[tr_cell_q] <= tr_bnd_q;
    end
  end

  // trail memory: push in ST_EXEC, pop-read in ST_UNWIND_RD
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && kind_q == OP_SET && cell_ok && !(rd_once_q && rd_bnd_q) &&
        need_trail && tcnt_q < TCNT_W'(TRAIL_DEPTH)) begin
      tcell_mem[TRAIL_W'(tcnt_q)] <= cidx;
      tval_mem[TRAIL_W'(tcnt_q)]  <= rd_val_q;
      tstp_mem[TRAIL_W'(tcnt_q)]  <= rd_stp_q;
      tbnd_mem[TRAIL_W'(tcnt_q)]  <= rd_bnd_q;
    end
    if (state_q == ST_UNWIND_RD) begin
      tr_cell_q <= tcell_mem[tpop];
      tr_val_q  <= tval_mem[tpop];
      tr_stp_q  <= tstp_mem[tpop];
      tr_bnd_q  <= tbnd_mem[tpop];
    end
  end

  // level stack: push on mark, read mark's slot in ST_READ
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && kind_q == OP_MARK && lcnt_q < LCNT_W'(LEVEL_DEPTH)) begin
      lbase_mem[LEVEL_W'(lcnt_q)] <= tcnt_q;
      lgen_mem[LEVEL_W'(lcnt_q)]  <= gen_q + 32'd1;
    end
    if (state_q == ST_READ) begin
      rd_base_q <= lbase_mem[mslot];
      rd_gen_q  <= lgen_mem[mslot];
    end
  end

  assign ok_o                  = ok_q;
  assign read_value_o          = rval_q;
  assign read_bound_o          = rbnd_q;
  assign new_mark_level_o      = nlvl_q;
  assign new_mark_generation_o = ngen_q;
  assign level_now_o           = 7'(lcnt_q);
  assign trail_now_o           = 11'(tcnt_q);
  assign trailing_paused_o     = (pcnt_q != 8'd0);
endmodule
`default_nettype wire

### bench/backtrack_trail_store_tb.sv
// Self-checking testbench for backtrack_trail_store: directed checks of every operation,
// level-stack overflow, pause saturation, multi-level trailing, then constrained-by-hand random traffic.
// Depends on bts_pkg and the backtrack_trail_store RTL.
`default_nettype none
module backtrack_trail_store_tb;
  import bts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct {
    logic        ok;
    logic [63:0] rval;
    logic        rbound;
    logic [6:0]  nlvl;
    logic [31:0] ngen;
    logic [6:0]  lnow;
    logic [10:0] tnow;
    logic        paused;
  } answer_t;

  typedef struct {
    logic [6:0]  lvl;
    logic [31:0] gen;
  } mark_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         kind_i = '0;
  logic [7:0]         cell_index_i = '0;
  logic signed [63:0] write_value_i = '0;
  logic               write_once_flag_i = 1'b0;
  logic [6:0]         mark_level_i = '0;
  logic [31:0]        mark_generation_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               ok_o;
  logic signed [63:0] read_value_o;
  logic               read_bound_o;
  logic [6:0]         new_mark_level_o;
  logic [31:0]        new_mark_generation_o;
  logic [6:0]         level_now_o;
  logic [10:0]        trail_now_o;
  logic               trailing_paused_o;

  // Mirror of the store's contents, kept in step with each accepted beat.
  logic [63:0] cell_val   [CELLS];
  logic [6:0]  cell_stamp [CELLS];
  logic        cell_bnd   [CELLS];
  logic        cell_once  [CELLS];
  bit          cell_known [CELLS];
  logic [7:0]  trail_cell  [TRAIL_DEPTH];
  logic [63:0] trail_val   [TRAIL_DEPTH];
  logic [6:0]  trail_stamp [TRAIL_DEPTH];
  logic        trail_bnd   [TRAIL_DEPTH];
  int unsigned lvl_base [LEVEL_DEPTH];
  logic [31:0] lvl_gen  [LEVEL_DEPTH];
  int unsigned trail_cnt, lvl_cnt, pause_cnt;
  logic [31:0] gen_cnt;

  answer_t     pending_answers[$];
  mark_t       marks_taken[$];
  int unsigned errors, beats_sent, beats_checked, cycles;
  bit          no_idle;
  int unsigned out_hold;

  backtrack_trail_store i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_answers.size());
      $display("backtrack_trail_store verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0d] mismatch on %s: got %0h, expected %0h", cycles, what, got, want);
    errors++;
  endtask

  // Pop trail entries down to base; restore the cells on undo, drop them on commit.
  function automatic logic unwind_to(input logic [6:0] lvl, input logic [31:0] gen,
                                     input bit restore);
    logic [7:0] c;
    if (lvl == 0 || lvl > lvl_cnt || lvl_gen[lvl-1] != gen) return 1'b0;
    while (trail_cnt > lvl_base[lvl-1]) begin
      trail_cnt--;
      if (restore) begin
        c = trail_cell[trail_cnt];
        cell_val[c]   = trail_val[trail_cnt];
        cell_stamp[c] = trail_stamp[trail_cnt];
        cell_bnd[c]   = trail_bnd[trail_cnt];
      end
    end
    lvl_cnt = lvl - 1;
    return 1'b1;
  endfunction

  function automatic answer_t apply_operation(input logic [3:0] kind, input logic [7:0] c,
                                              input logic [63:0] v, input logic once,
                                              input logic [6:0] mlvl, input logic [31:0] mgen);
    answer_t a;
    a = '{default: '0};
    case (kind)
      OP_INIT: begin
        cell_val[c] = v;
        cell_stamp[c] = 7'(lvl_cnt);
        cell_bnd[c] = !once;
        cell_once[c] = once;
        cell_known[c] = 1'b1;
        a.ok = 1'b1;
      end
      OP_SET: begin
        if (!(cell_once[c] && cell_bnd[c])) begin
          a.ok = 1'b1;
          if (lvl_cnt > 0 && pause_cnt == 0 && cell_stamp[c] < lvl_cnt) begin
            if (trail_cnt >= TRAIL_DEPTH) a.ok = 1'b0;
            else begin
              trail_cell[trail_cnt]  = c;
              trail_val[trail_cnt]   = cell_val[c];
              trail_stamp[trail_cnt] = cell_stamp[c];
              trail_bnd[trail_cnt]   = cell_bnd[c];
              trail_cnt++;
              cell_stamp[c] = 7'(lvl_cnt);
            end
          end
          if (a.ok) begin
            cell_val[c] = v;
            cell_bnd[c] = 1'b1;
          end
        end
      end
      OP_GET: begin
        a.rval = cell_val[c];
        a.rbound = cell_bnd[c];
        a.ok = 1'b1;
      end
      OP_MARK: begin
        if (lvl_cnt < LEVEL_DEPTH) begin
          gen_cnt++;
          lvl_base[lvl_cnt] = trail_cnt;
          lvl_gen[lvl_cnt] = gen_cnt;
          lvl_cnt++;
          a.nlvl = 7'(lvl_cnt);
          a.ngen = gen_cnt;
          a.ok = 1'b1;
          marks_taken.push_back('{lvl: a.nlvl, gen: a.ngen});
        end
      end
      OP_UNDO:   a.ok = unwind_to(mlvl, mgen, 1'b1);
      OP_COMMIT: a.ok = unwind_to(mlvl, mgen, 1'b0);
      OP_PAUSE: begin
        if (pause_cnt < 255) pause_cnt++;
        a.ok = 1'b1;
      end
      OP_RESUME: begin
        if (pause_cnt > 0) pause_cnt--;
        a.ok = 1'b1;
      end
      OP_RESET: begin
        trail_cnt = 0;
        lvl_cnt = 0;
        pause_cnt = 0;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    a.lnow = 7'(lvl_cnt);
    a.tnow = 11'(trail_cnt);
    a.paused = pause_cnt != 0;
    return a;
  endfunction

  // Present one beat, hold it until taken, predict its result, then idle a random gap unless no_idle is set.
  task automatic send_beat(input logic [3:0] kind, input logic [7:0] c,
                           input logic [63:0] v = '0, input logic once = 1'b0,
                           input logic [6:0] mlvl = '0, input logic [31:0] mgen = '0);
    int unsigned gap;
    kind_i <= kind;
    cell_index_i <= c;
    write_value_i <= v;
    write_once_flag_i <= once;
    mark_level_i <= mlvl;
    mark_generation_i <= mgen;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_answers.push_back(apply_operation(kind, c, v, once, mlvl, mgen));
    beats_sent++;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid so the last beat is not taken twice, then wait for every result.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check each beat against the oldest prediction, stall at random.
  always @(posedge clk_i) begin
    answer_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        beats_checked++;
        if (pending_answers.size() == 0) begin
          $display("[%0d] result beat with nothing expected", cycles);
          errors++;
        end else begin
          w = pending_answers.pop_front();
          if (ok_o !== w.ok) report_mismatch("ok", ok_o, w.ok);
          if (read_value_o !== w.rval) report_mismatch("read_value", read_value_o, w.rval);
          if (read_bound_o !== w.rbound) report_mismatch("read_bound", read_bound_o, w.rbound);
          if (new_mark_level_o !== w.nlvl)
            report_mismatch("new_mark_level", new_mark_level_o, w.nlvl);
          if (new_mark_generation_o !== w.ngen)
            report_mismatch("new_mark_generation", new_mark_generation_o, w.ngen);
          if (level_now_o !== w.lnow) report_mismatch("level_now", level_now_o, w.lnow);
          if (trail_now_o !== w.tnow) report_mismatch("trail_now", trail_now_o, w.tnow);
          if (trailing_paused_o !== w.paused)
            report_mismatch("trailing_paused", trailing_paused_o, w.paused);
        end
        out_hold = no_idle ? 0 : $urandom_range(0, 15);
      end else if (out_hold > 0) out_hold--;
      out_stall_i <= (out_hold != 0);
    end
  end

  // Every operation at least once, extreme values, write-once binding and refused marks.
  task automatic test_directed;
    mark_t m;
    send_beat(OP_INIT, 8'd0, 64'h8000_0000_0000_0000);
    send_beat(OP_INIT, 8'd255, 64'h7FFF_FFFF_FFFF_FFFF);
    send_beat(OP_INIT, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_beat(OP_GET, 8'd1);
    send_beat(OP_RESUME, 8'd0);
    send_beat(OP_MARK, 8'd0);
    m = marks_taken[$];
    send_beat(OP_SET, 8'd1, 64'h1234);
    send_beat(OP_SET, 8'd1, 64'h5678);
    send_beat(OP_SET, 8'd255, 64'd0);
    send_beat(OP_PAUSE, 8'd0);
    send_beat(OP_SET, 8'd0, 64'd7);
    send_beat(OP_RESUME, 8'd0);
    send_beat(OP_UNDO, 8'd0, '0, 1'b0, 7'd0, m.gen);
    send_beat(OP_UNDO, 8'd0, '0, 1'b0, 7'd127, m.gen);
    send_beat(OP_UNDO, 8'd0, '0, 1'b0, m.lvl, ~m.gen);
    send_beat(OP_UNDO, 8'd0, '0, 1'b0, m.lvl, m.gen);
    send_beat(OP_GET, 8'd1);
    send_beat(OP_GET, 8'd255);
    send_beat(OP_MARK, 8'd0);
    m = marks_taken[$];
    send_beat(OP_SET, 8'd0, 64'd99);
    send_beat(OP_COMMIT, 8'd0, '0, 1'b0, m.lvl, m.gen);
    send_beat(OP_GET, 8'd0);
    send_beat(4'd9, 8'd0);
    send_beat(4'd15, 8'd255);
    send_beat(OP_RESET, 8'd0);
    drain();
  endtask

  // Fill the level stack, take one mark too many, then try a commit to level 1 with the newest mark's generation.
  task automatic test_level_overflow;
    send_beat(OP_RESET, 8'd0);
    repeat (LEVEL_DEPTH + 1) send_beat(OP_MARK, 8'd0);
    send_beat(OP_COMMIT, 8'd0, '0, 1'b0, 7'd1, marks_taken[$].gen);
    drain();
  endtask

  // Trail a group of cells at several nested levels, then undo them all at once.
  task automatic test_trail_levels;
    mark_t first;
    no_idle = 1'b1;
    send_beat(OP_RESET, 8'd0);
    for (int c = 0; c < 32; c++) send_beat(OP_INIT, c[7:0], {$urandom, $urandom});
    for (int l = 0; l < 3; l++) begin
      send_beat(OP_MARK, 8'd0);
      if (l == 0) first = marks_taken[$];
      for (int c = 0; c < 32; c++) send_beat(OP_SET, c[7:0], {$urandom, $urandom});
    end
    send_beat(OP_UNDO, 8'd0, '0, 1'b0, first.lvl, first.gen);
    for (int c = 0; c < 32; c += 7) send_beat(OP_GET, c[7:0]);
    no_idle = 1'b0;
    drain();
  endtask

  // Drive the pause count into saturation, step it down, then resume at zero.
  task automatic test_pause_saturation;
    no_idle = 1'b1;
    repeat (257) send_beat(OP_PAUSE, 8'd0);
    repeat (2) send_beat(OP_RESUME, 8'd0);
    send_beat(OP_RESET, 8'd0);
    send_beat(OP_RESUME, 8'd0);
    no_idle = 1'b0;
    drain();
  endtask

  function automatic logic [7:0] pick_known_cell;
    logic [7:0] c;
    do c = 8'($urandom_range(0, CELLS - 1)); while (!cell_known[c]);
    return c;
  endfunction

  // Mostly well-formed traffic on initialised cells; some noise and stale marks.
  task automatic test_random(input int unsigned count);
    int unsigned r;
    logic [6:0]  ml;
    logic [31:0] mg;
    mark_t       m;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) send_beat(OP_INIT, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                            1'($urandom_range(0, 1)));
      else if (r < 42) send_beat(OP_SET, pick_known_cell(), {$urandom, $urandom});
      else if (r < 60) send_beat(OP_GET, pick_known_cell());
      else if (r < 70) send_beat(OP_MARK, 8'($urandom_range(0, 255)));
      else if (r < 84) begin
        if (marks_taken.size() != 0 && $urandom_range(0, 9) != 0) begin
          m = marks_taken[marks_taken.size() - 1 - $urandom_range(0,
                  marks_taken.size() > 8 ? 7 : marks_taken.size() - 1)];
          ml = m.lvl;
          mg = ($urandom_range(0, 7) == 0) ? m.gen ^ (32'h1 << $urandom_range(0, 31)) : m.gen;
        end else begin
          ml = 7'($urandom_range(0, 127));
          mg = $urandom;
        end
        send_beat((r < 78) ? OP_UNDO : OP_COMMIT, 8'($urandom_range(0, 255)),
                  {$urandom, $urandom}, 1'($urandom_range(0, 1)), ml, mg);
      end
      else if (r < 90) send_beat(OP_PAUSE, 8'd0);
      else if (r < 96) send_beat(OP_RESUME, 8'd0);
      else if (r < 98) send_beat(OP_RESET, 8'd0);
      else send_beat(4'($urandom_range(9, 15)), 8'($urandom_range(0, 255)),
                     {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                     7'($urandom_range(0, 127)), $urandom);
    end
    drain();
  endtask

  initial begin
    beats_sent = 0;
    no_idle = 1'b0;
    trail_cnt = 0;
    lvl_cnt = 0;
    pause_cnt = 0;
    gen_cnt = 32'd1;
    foreach (cell_known[i]) cell_known[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_level_overflow();
    test_pause_saturation();
    test_trail_levels();
    test_random(400);

    repeat (40) @(posedge clk_i);
    $display("covered %0d beats in, %0d results checked, %0d marks taken, %0d cycles",
             beats_sent, beats_checked, marks_taken.size(), cycles);
    $display("including level-stack overflow, nested trailing, pause saturation and stale marks");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("backtrack_trail_store verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_answers.size());
      $display("backtrack_trail_store verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
